// ===== rtl/substring_move_text_buffer_macros.svh =====
// assertion macros for the substring move text buffer
// used by substring_move_text_buffer.sv, no other dependencies
`ifndef SUBSTRING_MOVE_TEXT_BUFFER_MACROS_SVH
`define SUBSTRING_MOVE_TEXT_BUFFER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SMTB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SMTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/smtb_pkg.sv =====
// shared constants and types for the substring move text buffer
// no dependencies
`timescale 1ns / 1ps

package smtb_pkg;

  localparam int BUF_DEPTH = 1024;
  localparam int LOG_DEPTH = 256;
  localparam int POS_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W     = POS_W + 1;
  localparam int LOG_AW    = $clog2(LOG_DEPTH);
  localparam int CNT_W     = LOG_AW + 1;
  localparam int X_W       = 20;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FRONT = 2'd1,
    OP_BACK  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REB_NEXT,
    ST_LOG_RD,
    ST_WALK,
    ST_MEM_RD,
    ST_MEM_WAIT
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic             to_back;
  } log_entry_t;

endpackage

// ===== rtl/substring_move_text_buffer.sv =====
// substring move text buffer: two byte stores, a move log and a log walker
// depends on smtb_pkg and substring_move_text_buffer_macros.svh
`timescale 1ns / 1ps
`include "substring_move_text_buffer_macros.svh"

// channel   ports                                             handshake
// input     in_opcode in_first_pos in_last_pos in_char_in     start, busy
// result    out_char_out                                      out_valid strobe
// config    cfg_wr_data (text_length)                         cfg_wr_en
//
// busy after acceptance: a query or a load first walks the log, newest entry first,
// through the single log read port; an empty log skips the log read. a move only
// writes at most one log entry; the move that fills the log adds a rebuild that
// copies every store position into the inactive store.
// reset is synchronous; there is no clearing pass. results cannot be stalled.

module substring_move_text_buffer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_opcode,
  input  logic [9:0]              in_first_pos,
  input  logic [9:0]              in_last_pos,
  input  logic [7:0]              in_char_in,
  output logic                    out_valid,
  output logic [7:0]              out_char_out,
  input  logic                    cfg_wr_en,
  input  logic [10:0]             cfg_wr_data
);
  import smtb_pkg::*;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  text_len_r;
  op_t               op_r, op_nxt;
  logic [POS_W-1:0]  first_r, first_nxt;
  logic [POS_W-1:0]  last_r, last_nxt;
  logic [7:0]        char_r, char_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [LOG_AW-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  log_cnt_r, log_cnt_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic              side_r, side_nxt;
  logic              reb_r, reb_nxt;

  // memories
  logic [7:0]        main_mem [BUF_DEPTH];
  logic [7:0]        alt_mem  [BUF_DEPTH];
  log_entry_t        log_mem  [LOG_DEPTH];
  logic [7:0]        main_q, alt_q;
  log_entry_t        log_q;

  logic [POS_W-1:0]  st_raddr, st_waddr;
  logic [7:0]        st_wdata;
  logic              we_main, we_alt;
  logic [LOG_AW-1:0] log_raddr;
  logic              log_we;
  log_entry_t        log_wdata;

  // effective length and clamped positions
  logic [LEN_W-1:0]  len;
  logic [POS_W-1:0]  a_pos, b_pos;
  logic              move_noop;

  always_comb begin
    if (text_len_r == '0) begin
      len = LEN_W'(1);
    end else if (text_len_r > LEN_W'(BUF_DEPTH)) begin
      len = LEN_W'(BUF_DEPTH);
    end else begin
      len = text_len_r;
    end
    a_pos = ({1'b0, first_r} >= len) ? POS_W'(len - LEN_W'(1)) : first_r;
    b_pos = ({1'b0, last_r} >= len) ? POS_W'(len - LEN_W'(1)) : last_r;
    move_noop = (a_pos > b_pos) ||
                ((op_r == OP_FRONT) && (a_pos == '0)) ||
                ((op_r == OP_BACK) && ({1'b0, b_pos} == len - LEN_W'(1)));
  end

  // one backward translation step through the log entry in log_q
  logic [X_W:0]      t_front, t_back, back_wrap;
  logic [X_W-1:0]    x_step;
  logic [POS_W-1:0]  span;

  always_comb begin
    span      = log_q.end_pos - log_q.start_pos;
    t_front   = {1'b0, x_r} + (X_W+1)'(log_q.start_pos);
    t_back    = {1'b0, x_r} + (X_W+1)'(span) + (X_W+1)'(1);
    back_wrap = t_back - (X_W+1)'(len) + (X_W+1)'(log_q.start_pos);
    x_step    = x_r;
    if (!log_q.to_back) begin
      if (x_r <= X_W'(log_q.end_pos)) begin
        if (x_r <= X_W'(span)) begin
          x_step = t_front[X_W-1:0];
        end else begin
          x_step = X_W'(t_front - (X_W+1)'(log_q.end_pos) - (X_W+1)'(1));
        end
      end
    end else begin
      if (x_r >= X_W'(log_q.start_pos)) begin
        if (t_back >= (X_W+1)'(len)) begin
          x_step = back_wrap[X_W-1:0];
        end else begin
          x_step = t_back[X_W-1:0];
        end
      end
    end
  end

  // saturated store slot
  logic [POS_W-1:0] x_slot;
  assign x_slot = (x_r >= X_W'(BUF_DEPTH)) ? POS_W'(BUF_DEPTH - 1) : x_r[POS_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (op_r == OP_LOAD || op_r == OP_QUERY) begin
          state_nxt = (log_cnt_r == '0) ? ST_MEM_RD : ST_LOG_RD;
        end else if (move_noop) begin
          state_nxt = ST_IDLE;
        end else if (log_cnt_r == CNT_W'(LOG_DEPTH - 1)) begin
          state_nxt = ST_REB_NEXT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REB_NEXT: begin
        state_nxt = (pos_r < len) ? ST_LOG_RD : ST_MEM_RD;
      end
      ST_LOG_RD: state_nxt = ST_WALK;
      ST_WALK: begin
        if (idx_r == '0) state_nxt = ST_MEM_RD;
      end
      ST_MEM_RD: begin
        state_nxt = (!reb_r && op_r == OP_LOAD) ? ST_IDLE : ST_MEM_WAIT;
      end
      ST_MEM_WAIT: begin
        if (!reb_r || pos_r == LEN_W'(BUF_DEPTH - 1)) state_nxt = ST_IDLE;
        else state_nxt = ST_REB_NEXT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_nxt      = op_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    char_nxt    = char_r;
    x_nxt       = x_r;
    idx_nxt     = idx_r;
    log_cnt_nxt = log_cnt_r;
    pos_nxt     = pos_r;
    side_nxt    = side_r;
    reb_nxt     = reb_r;
    st_raddr    = x_slot;
    st_waddr    = x_slot;
    st_wdata    = char_r;
    we_main     = 1'b0;
    we_alt      = 1'b0;
    log_raddr   = idx_r;
    log_we      = 1'b0;
    log_wdata   = '{start_pos: a_pos, end_pos: b_pos, to_back: (op_r == OP_BACK)};
    busy        = (state_r != ST_IDLE);
    out_valid   = 1'b0;
    out_char_out = side_r ? alt_q : main_q;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = op_t'(in_opcode);
          first_nxt = in_first_pos;
          last_nxt  = in_last_pos;
          char_nxt  = in_char_in;
          reb_nxt   = 1'b0;
        end
      end
      ST_DECODE: begin
        x_nxt = X_W'(a_pos);
        if (op_r == OP_FRONT || op_r == OP_BACK) begin
          if (!move_noop) begin
            log_we      = 1'b1;
            log_cnt_nxt = log_cnt_r + CNT_W'(1);
            if (log_cnt_r == CNT_W'(LOG_DEPTH - 1)) begin
              reb_nxt = 1'b1;
              pos_nxt = '0;
            end
          end
        end
      end
      ST_REB_NEXT: begin
        x_nxt = X_W'(pos_r);
      end
      ST_LOG_RD: begin
        log_raddr = LOG_AW'(log_cnt_r - CNT_W'(1));
        idx_nxt   = LOG_AW'(log_cnt_r - CNT_W'(1));
      end
      ST_WALK: begin
        x_nxt = x_step;
        if (idx_r != '0) begin
          log_raddr = idx_r - LOG_AW'(1);
          idx_nxt   = idx_r - LOG_AW'(1);
        end
      end
      ST_MEM_RD: begin
        if (!reb_r && op_r == OP_LOAD) begin
          we_main = !side_r;
          we_alt  = side_r;
        end
      end
      ST_MEM_WAIT: begin
        if (reb_r) begin
          // copy into the inactive store at the current position
          st_waddr = pos_r[POS_W-1:0];
          st_wdata = side_r ? alt_q : main_q;
          we_main  = side_r;
          we_alt   = !side_r;
          pos_nxt  = pos_r + LEN_W'(1);
          if (pos_r == LEN_W'(BUF_DEPTH - 1)) begin
            side_nxt    = !side_r;
            log_cnt_nxt = '0;
            reb_nxt     = 1'b0;
          end
        end else begin
          out_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      text_len_r <= LEN_W'(1);
      log_cnt_r  <= '0;
      side_r     <= 1'b0;
      reb_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      log_cnt_r  <= log_cnt_nxt;
      side_r     <= side_nxt;
      reb_r      <= reb_nxt;
      if (cfg_wr_en) text_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    char_r  <= char_nxt;
    x_r     <= x_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
  end

  always_ff @(posedge clk) begin
    main_q <= main_mem[st_raddr];
    alt_q  <= alt_mem[st_raddr];
    if (we_main) main_mem[st_waddr] <= st_wdata;
    if (we_alt) alt_mem[st_waddr] <= st_wdata;
  end

  always_ff @(posedge clk) begin
    log_q <= log_mem[log_raddr];
    if (log_we) log_mem[log_cnt_r[LOG_AW-1:0]] <= log_wdata;
  end

  `SMTB_ASSERT_SAME(a_result_is_query, out_valid, (op_r == OP_QUERY) && !reb_r, "result without query")
  `SMTB_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy, "accepted word did not start work")
  `SMTB_ASSERT_SAME(a_log_below_full, !busy, log_cnt_r < CNT_W'(LOG_DEPTH), "full log left unrebuilt")
  `SMTB_ASSERT_NEXT(a_rebuild_flips, reb_r && !reb_nxt, side_r != $past(side_r), "rebuild did not swap stores")

endmodule

// ===== test/tb_substring_move_text_buffer.sv =====
// testbench for substring_move_text_buffer: directed and random load, move and query words
// depends on smtb_pkg and the rtl of substring_move_text_buffer
`timescale 1ns / 1ps

module tb_substring_move_text_buffer;
  import smtb_pkg::*;

  localparam int IDLE_LIMIT = 1000000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_opcode;
  logic [9:0] in_first_pos;
  logic [9:0] in_last_pos;
  logic [7:0] in_char_in;
  logic       out_valid;
  logic [7:0] out_char_out;
  logic       cfg_wr_en;
  logic [10:0] cfg_wr_data;

  substring_move_text_buffer DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_first_pos(in_first_pos), .in_last_pos(in_last_pos),
    .in_char_in(in_char_in), .out_valid(out_valid), .out_char_out(out_char_out),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // shadow of the text buffer
  logic [7:0]  text_mem [2][BUF_DEPTH];
  bit          text_set [2][BUF_DEPTH];
  int          move_from [LOG_DEPTH];
  int          move_to [LOG_DEPTH];
  bit          move_back [LOG_DEPTH];
  int          moves_held;
  int          side;
  logic [10:0] len_reg;

  logic [7:0]  char_queue [$];
  int          errors;
  int          words_sent;
  int          chars_checked;
  int          rebuilds;
  int          burst_left;
  int          idle_cycles;

  function automatic int cur_len();
    if (len_reg == 0) return 1;
    if (len_reg > BUF_DEPTH) return BUF_DEPTH;
    return len_reg;
  endfunction

  function automatic int clamp_to(int p, int len);
    return (p >= len) ? len - 1 : p;
  endfunction

  // walk the move log newest first back to a slot of the active store
  function automatic int slot_of(int x, int len);
    int s;
    int e;
    for (int i = moves_held - 1; i >= 0; i--) begin
      s = move_from[i];
      e = move_to[i];
      if (!move_back[i]) begin
        if (x <= e) begin
          if (x <= e - s) x = x + s;
          else x = (x + s) % (e + 1);
        end
      end else if (x >= s) begin
        x = x + (e - s + 1);
        if (x >= len) x = x - (len - s);
      end
    end
    if (x < 0) x = 0;
    if (x >= BUF_DEPTH) x = BUF_DEPTH - 1;
    return x;
  endfunction

  function automatic bit pos_written(int p);
    int len;
    len = cur_len();
    return text_set[side][slot_of(clamp_to(p, len), len)];
  endfunction

  function automatic void apply_word(op_t op, int fp, int lp, logic [7:0] ch);
    int len;
    int a;
    int b;
    int slot;
    len = cur_len();
    a = clamp_to(fp, len);
    b = clamp_to(lp, len);
    case (op)
      OP_LOAD: begin
        slot = slot_of(a, len);
        text_mem[side][slot] = ch;
        text_set[side][slot] = 1'b1;
      end
      OP_QUERY: begin
        char_queue.push_back(text_mem[side][slot_of(a, len)]);
      end
      default: begin
        if (a > b) return;
        if (op == OP_FRONT && a == 0) return;
        if (op == OP_BACK && b == len - 1) return;
        if (moves_held >= LOG_DEPTH) moves_held = 0;
        move_from[moves_held] = a;
        move_to[moves_held] = b;
        move_back[moves_held] = (op == OP_BACK);
        moves_held++;
        if (moves_held >= LOG_DEPTH) begin
          // log full: copy the text in order into the other store
          for (int p = 0; p < BUF_DEPTH; p++) begin
            slot = (p < len) ? slot_of(p, len) : p;
            text_mem[side ^ 1][p] = text_mem[side][slot];
            text_set[side ^ 1][p] = text_set[side][slot];
          end
          side = side ^ 1;
          moves_held = 0;
          rebuilds++;
        end
      end
    endcase
  endfunction

  task automatic send_word(op_t op, int fp, int lp, logic [7:0] ch);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_opcode <= op;
    in_first_pos <= fp[9:0];
    in_last_pos <= lp[9:0];
    in_char_in <= ch;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_word(op, fp, lp, ch);
    words_sent++;
  endtask

  // queries of never loaded characters become loads
  task automatic send_safe(op_t op, int fp, int lp, logic [7:0] ch);
    if (op == OP_QUERY && !pos_written(fp)) op = OP_LOAD;
    send_word(op, fp, lp, ch);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (char_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_length(logic [10:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_reg = value;
    @(posedge clk);
  endtask

  task automatic fill_text(int len);
    for (int p = 0; p < len; p++) send_word(OP_LOAD, p, 0, $urandom_range(0, 255));
  endtask

  task automatic test_reset_length();
    send_word(OP_LOAD, 0, 0, 8'hff);
    send_word(OP_QUERY, 1023, 0, 8'h00);
    send_word(OP_FRONT, 0, 1023, 8'h00);
    send_word(OP_BACK, 1023, 0, 8'h00);
    send_word(OP_QUERY, 0, 0, 8'h00);
  endtask

  task automatic test_directed_moves();
    write_length(11'd8);
    fill_text(8);
    send_word(OP_LOAD, 0, 0, 8'h00);
    send_word(OP_FRONT, 3, 5, 8'h00);
    send_word(OP_QUERY, 0, 0, 8'h00);
    send_word(OP_BACK, 1, 2, 8'h00);
    send_word(OP_QUERY, 7, 0, 8'h00);
    send_word(OP_FRONT, 6, 2, 8'h00);   // reversed range
    send_word(OP_FRONT, 0, 4, 8'h00);   // already at the front
    send_word(OP_BACK, 5, 1023, 8'h00); // clamped end, already at the back
    send_word(OP_FRONT, 4, 1023, 8'h00);
    send_word(OP_BACK, 0, 0, 8'h00);
    send_word(OP_LOAD, 1023, 0, 8'haa);
    for (int p = 0; p < 8; p++) send_word(OP_QUERY, p, 0, 8'h00);
    send_word(OP_QUERY, 1023, 0, 8'h00);
  endtask

  task automatic test_length_extremes();
    write_length(11'd0);
    send_word(OP_LOAD, 5, 0, 8'h5a);
    send_word(OP_QUERY, 0, 0, 8'h00);
    write_length(11'd2047);
    send_word(OP_LOAD, 1023, 0, 8'h81);
    send_word(OP_LOAD, 0, 0, 8'h7e);
    send_word(OP_FRONT, 1000, 1023, 8'h00);
    send_safe(OP_QUERY, 23, 0, 8'h00);
    send_safe(OP_QUERY, 0, 0, 8'h00);
    write_length(11'd1024);
    send_safe(OP_QUERY, 1023, 0, 8'h00);
  endtask

  task automatic random_word(int len);
    op_t op;
    int  fp;
    int  lp;
    op = op_t'($urandom_range(0, 3));
    fp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, len - 1);
    lp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, len - 1);
    if ((op == OP_FRONT || op == OP_BACK) && $urandom_range(0, 7) != 0 && fp > lp) begin
      fp = fp ^ lp; lp = fp ^ lp; fp = fp ^ lp;
    end
    // keep rebuilds to short texts
    if ((op == OP_FRONT || op == OP_BACK) && len > 64 && moves_held >= LOG_DEPTH - 4)
      op = OP_QUERY;
    send_safe(op, fp, lp, $urandom_range(0, 255));
  endtask

  task automatic test_log_rebuild();
    int len;
    write_length(11'd12);
    len = 12;
    fill_text(len);
    while (rebuilds == 0 || moves_held < 20) begin
      if ($urandom_range(0, 5) == 0) random_word(len);
      else send_safe(op_t'($urandom_range(1, 2)), $urandom_range(1, 5), $urandom_range(5, 10),
                     8'h00);
    end
    for (int p = 0; p < len; p++) send_word(OP_QUERY, p, 0, 8'h00);
  endtask

  task automatic test_random();
    int len;
    int n;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: len = 1;
        1: len = 2;
        2: len = 1024;
        default: len = $urandom_range(3, 40);
      endcase
      write_length(len[10:0]);
      fill_text((len > 48) ? 48 : len);
      n = (len > 64) ? 30 : 40;
      repeat (n) random_word(len);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (char_queue.size() == 0) begin
        $display("%0t: unexpected char_out, expected none, actual %0h", $time, out_char_out);
        errors++;
      end else begin
        if (out_char_out !== char_queue[0]) begin
          $display("%0t: char_out mismatch, expected %0h, actual %0h", $time,
                   char_queue[0], out_char_out);
          errors++;
        end
        void'(char_queue.pop_front());
        chars_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_LOAD;
    in_first_pos = '0;
    in_last_pos = '0;
    in_char_in = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    words_sent = 0;
    chars_checked = 0;
    rebuilds = 0;
    burst_left = 0;
    idle_cycles = 0;
    moves_held = 0;
    side = 0;
    len_reg = 11'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_length();
    test_directed_moves();
    test_length_extremes();
    test_log_rebuild();
    test_random();
    wait_idle();
    repeat (300) @(posedge clk);
    if (char_queue.size() != 0) begin
      $display("%0t: %0d query results never arrived", $time, char_queue.size());
      errors++;
    end
    $display("sent %0d words, checked %0d query results, %0d log rebuilds",
             words_sent, chars_checked, rebuilds);
    $display("lengths 0 to 2047 written, moves to front and back, clamped positions");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
